@@ rtl/nntt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nntt_pkg
// Shared constants, codes and types for the track table.
// ----------------------------------------------------------------------------
package nntt_pkg;
    localparam int TRACK_SLOTS_DEF = 16;
    localparam int COORD_BITS_DEF  = 12;
    localparam int ID_BITS         = 16;
    localparam int TIME_BITS       = 32;
    localparam int GATE_BITS       = 12;
    localparam int TMO_BITS        = 20;

    localparam logic [1:0] ST_MATCH   = 2'd0;
    localparam logic [1:0] ST_NEW     = 2'd1;
    localparam logic [1:0] ST_DROP    = 2'd2;
    localparam logic [1:0] ST_CLOSED  = 2'd3;

    localparam logic CFG_GATE = 1'b0;
    localparam logic CFG_TMO  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WRITE,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

@@ rtl/nntt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nntt_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module nntt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] addr,
    input  wire  [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ rtl/nearest_neighbor_track_table_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_track_table_top
// A transaction is scanned against the track memory one slot read per cycle,
// followed by the last read and then the write-back before the result is
// valid. Frame ends scan the same way. One transaction at a time: no new
// input is accepted until the result has been taken. Reset clears valid,
// fresh, next ID and the registers to their defaults; the memory needs no
// clearing.
// ----------------------------------------------------------------------------
module nearest_neighbor_track_table_top #(
    parameter int TRACK_SLOTS = nntt_pkg::TRACK_SLOTS_DEF,
    parameter int COORD_BITS  = nntt_pkg::COORD_BITS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire                         cfg_index,
    input  wire  [31:0]                 cfg_data,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire                         func,
    input  wire  [COORD_BITS-1:0]       x_pos,
    input  wire  [COORD_BITS-1:0]       y_pos,
    input  wire  [31:0]                 now_ms,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [1:0]                  status,
    output logic [15:0]                 track_id,
    output logic [$clog2(TRACK_SLOTS+1)-1:0] removed_count,
    output logic [$clog2(TRACK_SLOTS+1)-1:0] active_count
);
    localparam int AW = $clog2(TRACK_SLOTS);
    localparam int CW = $clog2(TRACK_SLOTS + 1);
    localparam int DW = 2 * COORD_BITS + 1;
    localparam int QW = (DW > 2 * nntt_pkg::GATE_BITS) ? DW : 2 * nntt_pkg::GATE_BITS;
    localparam int MW = nntt_pkg::ID_BITS + 2 * COORD_BITS + nntt_pkg::TIME_BITS;

    nntt_pkg::state_t state_reg, state_next;

    logic [nntt_pkg::GATE_BITS-1:0] gate_reg;
    logic [nntt_pkg::TMO_BITS-1:0]  tmo_reg;
    logic [TRACK_SLOTS-1:0] valid_reg, fresh_reg;
    logic [15:0] nid_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [31:0] now_reg;
    logic [AW:0] cnt_reg;
    logic [AW-1:0] rd_slot_reg;
    logic rd_ok_reg;
    logic found_reg;
    logic [AW-1:0] best_reg;
    logic [QW-1:0] bd2_reg;
    logic [15:0] bage_reg, bid_reg;
    logic [QW-1:0] gate2_reg;
    logic [1:0] st_reg;
    logic [15:0] id_reg;
    logic [CW-1:0] rem_reg;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [MW-1:0] ram_wdata, ram_rdata;

    nntt_ram #(.WIDTH(MW), .DEPTH(TRACK_SLOTS)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic [15:0] r_id;
    logic [COORD_BITS-1:0] r_x, r_y;
    logic [31:0] r_time;
    assign {r_id, r_x, r_y, r_time} = ram_rdata;

    logic [COORD_BITS-1:0] dx, dy;
    logic [QW-1:0] d2;
    logic [15:0] age;
    logic take;
    assign dx = (x_reg > r_x) ? x_reg - r_x : r_x - x_reg;
    assign dy = (y_reg > r_y) ? y_reg - r_y : r_y - y_reg;
    assign d2 = QW'({COORD_BITS'(0), dx} * {COORD_BITS'(0), dx})
              + QW'({COORD_BITS'(0), dy} * {COORD_BITS'(0), dy});
    assign age = nid_reg - r_id;
    assign take = rd_ok_reg && valid_reg[rd_slot_reg] && !fresh_reg[rd_slot_reg]
               && (d2 < gate2_reg)
               && (!found_reg || d2 < bd2_reg || (d2 == bd2_reg && age < bage_reg));

    logic free_found;
    logic [AW-1:0] free_slot;
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int k = TRACK_SLOTS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_found = 1'b1;
                free_slot  = AW'(k);
            end
        end
    end

    // Sweep uses stored times, so the frame end also scans the memory.
    logic sweep_hit;
    assign sweep_hit = rd_ok_reg && valid_reg[rd_slot_reg]
                    && ((now_reg - r_time) > {12'd0, tmo_reg});

    logic [15:0] nid_inc;
    assign nid_inc = (nid_reg + 16'd1 == 16'd0) ? 16'd1 : nid_reg + 16'd1;

    logic func_reg;
    logic [CW-1:0] pop;
    always_comb
    begin
        pop = '0;
        for (int k = 0; k < TRACK_SLOTS; k++)
        begin
            pop = pop + CW'(valid_reg[k]);
        end
    end

    assign in_ready  = (state_reg == nntt_pkg::S_IDLE);
    assign cfg_ready = (state_reg == nntt_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nntt_pkg::S_IDLE:  if (in_valid) state_next = nntt_pkg::S_SCAN;
            nntt_pkg::S_SCAN:  if (cnt_reg == (AW+1)'(TRACK_SLOTS - 1))
                                   state_next = nntt_pkg::S_LAST;
            nntt_pkg::S_LAST:  state_next = nntt_pkg::S_WRITE;
            nntt_pkg::S_WRITE: state_next = nntt_pkg::S_OUT;
            nntt_pkg::S_OUT:   if (out_ready) state_next = nntt_pkg::S_IDLE;
            default:           state_next = nntt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = cnt_reg[AW-1:0];
        ram_wdata = {bid_reg, x_reg, y_reg, now_reg};
        if (state_reg == nntt_pkg::S_WRITE && !func_reg)
        begin
            if (found_reg)
            begin
                ram_we   = 1'b1;
                ram_addr = best_reg;
            end
            else if (free_found)
            begin
                ram_we    = 1'b1;
                ram_addr  = free_slot;
                ram_wdata = {nid_inc, x_reg, y_reg, now_reg};
            end
        end
    end

    assign out_valid     = (state_reg == nntt_pkg::S_OUT);
    assign status        = st_reg;
    assign track_id      = id_reg;
    assign removed_count = rem_reg;
    assign active_count  = pop;

    always_ff @(posedge clk)
    begin
        if (state_reg == nntt_pkg::S_IDLE && in_valid)
        begin
            func_reg <= func;
            x_reg    <= x_pos;
            y_reg    <= y_pos;
            now_reg  <= now_ms;
            gate2_reg <= QW'({nntt_pkg::GATE_BITS'(0), gate_reg}
                           * {nntt_pkg::GATE_BITS'(0), gate_reg});
        end
        if (take && !func_reg)
        begin
            best_reg <= rd_slot_reg;
            bd2_reg  <= d2;
            bage_reg <= age;
            bid_reg  <= r_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nntt_pkg::S_IDLE;
            gate_reg  <= nntt_pkg::GATE_BITS'(40);
            tmo_reg   <= nntt_pkg::TMO_BITS'(2000);
            valid_reg <= '0;
            fresh_reg <= '0;
            nid_reg   <= '0;
            cnt_reg   <= '0;
            rd_slot_reg <= '0;
            rd_ok_reg <= 1'b0;
            found_reg <= 1'b0;
            st_reg    <= '0;
            id_reg    <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == nntt_pkg::CFG_GATE)
                    gate_reg <= cfg_data[nntt_pkg::GATE_BITS-1:0];
                else
                    tmo_reg <= cfg_data[nntt_pkg::TMO_BITS-1:0];
            end
            rd_ok_reg   <= (state_reg == nntt_pkg::S_SCAN);
            rd_slot_reg <= cnt_reg[AW-1:0];
            case (state_reg)
                nntt_pkg::S_IDLE:
                begin
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    rem_reg   <= '0;
                end
                nntt_pkg::S_SCAN:
                begin
                    cnt_reg <= cnt_reg + (AW+1)'(1);
                end
                default:
                begin
                end
            endcase
            if (func_reg && sweep_hit)
            begin
                valid_reg[rd_slot_reg] <= 1'b0;
                rem_reg <= rem_reg + CW'(1);
            end
            if (!func_reg && take)
            begin
                found_reg <= 1'b1;
            end
            if (state_reg == nntt_pkg::S_WRITE)
            begin
                if (func_reg)
                begin
                    st_reg    <= nntt_pkg::ST_CLOSED;
                    id_reg    <= '0;
                    fresh_reg <= '0;
                end
                else if (found_reg)
                begin
                    st_reg <= nntt_pkg::ST_MATCH;
                    id_reg <= bid_reg;
                end
                else if (free_found)
                begin
                    st_reg <= nntt_pkg::ST_NEW;
                    id_reg <= nid_inc;
                    nid_reg <= nid_inc;
                    valid_reg[free_slot] <= 1'b1;
                    fresh_reg[free_slot] <= 1'b1;
                end
                else
                begin
                    st_reg <= nntt_pkg::ST_DROP;
                    id_reg <= '0;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/nntt_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nntt_checker
// Port-level checks on the track table, bound to the top level.
// ----------------------------------------------------------------------------
module nntt_checker #(
    parameter int CW = 5
) (
    input wire          clk,
    input wire          rst_n,
    input wire          in_valid,
    input wire          in_ready,
    input wire          out_valid,
    input wire          out_ready,
    input wire [1:0]    status,
    input wire [15:0]   track_id,
    input wire [CW-1:0] removed_count
);
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("Result changed while stalled.");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("Input accepted while a result is pending.");
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == nntt_pkg::ST_DROP || status == nntt_pkg::ST_CLOSED)
        |-> track_id == 16'd0)
        else $error("Track ID set on drop or frame close.");
    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != nntt_pkg::ST_CLOSED |-> removed_count == '0)
        else $error("Removed count set on a detection.");
endmodule

bind nearest_neighbor_track_table_top nntt_checker #(.CW($clog2(TRACK_SLOTS + 1))) u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .track_id(track_id), .removed_count(removed_count)
);
`default_nettype wire

@@ test/nearest_neighbor_track_table_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Track table testbench
// Drives detections and frame ends through the valid/ready channels, writes
// the gate radius and timeout registers between phases, and checks every
// result against an in-bench model of the nearest-neighbor track table.
// ----------------------------------------------------------------------------
module nearest_neighbor_track_table_top_tb;
    localparam int SLOTS = 16;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] track_id;
        logic [4:0]  removed;
        logic [4:0]  active;
    } track_result_t;

    class track_table_scoreboard;
        bit             slot_used  [SLOTS];
        bit             slot_new   [SLOTS];
        logic [15:0]    slot_ident [SLOTS];
        logic [11:0]    slot_col   [SLOTS];
        logic [11:0]    slot_row   [SLOTS];
        logic [31:0]    slot_stamp [SLOTS];
        logic [15:0]    last_id;
        logic [11:0]    gate;
        logic [19:0]    idle_limit;
        track_result_t  pending[$];
        int             mismatches;

        function new();
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_used[k] = 0;
                slot_new[k]  = 0;
            end
            last_id    = '0;
            gate       = 12'd40;
            idle_limit = 20'd2000;
            mismatches = 0;
        endfunction

        function void set_register(logic idx, logic [31:0] data);
            if (idx == nntt_pkg::CFG_GATE)
                gate = data[11:0];
            else
                idle_limit = data[19:0];
        endfunction

        function void note_transaction(logic f, logic [11:0] x, logic [11:0] y,
                                       logic [31:0] now);
            track_result_t r;
            longint        gate2;
            longint        dx;
            longint        dy;
            longint        d2;
            longint        best_d2;
            logic [15:0]   age;
            logic [15:0]   best_age;
            int            best;
            int            free_slot;
            int            n;
            r = '0;
            best = -1;
            best_d2 = 0;
            best_age = 0;
            free_slot = -1;
            if (f)
            begin
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (slot_used[k] && (now - slot_stamp[k]) > {12'd0, idle_limit})
                    begin
                        slot_used[k] = 0;
                        r.removed++;
                    end
                    slot_new[k] = 0;
                end
                r.status = nntt_pkg::ST_CLOSED;
            end
            else
            begin
                gate2 = longint'(gate) * longint'(gate);
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (!slot_used[k] || slot_new[k])
                        continue;
                    dx = longint'(x) - longint'(slot_col[k]);
                    dy = longint'(y) - longint'(slot_row[k]);
                    d2 = dx * dx + dy * dy;
                    if (d2 >= gate2)
                        continue;
                    age = last_id - slot_ident[k];
                    if (best < 0 || d2 < best_d2 || (d2 == best_d2 && age < best_age))
                    begin
                        best = k;
                        best_d2 = d2;
                        best_age = age;
                    end
                end
                if (best >= 0)
                begin
                    slot_col[best] = x;
                    slot_row[best] = y;
                    slot_stamp[best] = now;
                    r.track_id = slot_ident[best];
                    r.status = nntt_pkg::ST_MATCH;
                end
                else
                begin
                    for (int k = SLOTS - 1; k >= 0; k--)
                        if (!slot_used[k])
                            free_slot = k;
                    if (free_slot >= 0)
                    begin
                        last_id = last_id + 16'd1;
                        if (last_id == 16'd0)
                            last_id = 16'd1;
                        slot_used[free_slot]  = 1;
                        slot_new[free_slot]   = 1;
                        slot_ident[free_slot] = last_id;
                        slot_col[free_slot]   = x;
                        slot_row[free_slot]   = y;
                        slot_stamp[free_slot] = now;
                        r.track_id = last_id;
                        r.status = nntt_pkg::ST_NEW;
                    end
                    else
                        r.status = nntt_pkg::ST_DROP;
                end
            end
            n = 0;
            for (int k = 0; k < SLOTS; k++)
                if (slot_used[k])
                    n++;
            r.active = n[4:0];
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(track_result_t got);
            track_result_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status || got.track_id !== exp_r.track_id ||
                got.removed !== exp_r.removed || got.active !== exp_r.active)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected status=%0d id=%0d removed=%0d ",
                              "active=%0d, got status=%0d id=%0d removed=%0d active=%0d"},
                             exp_r.status, exp_r.track_id, exp_r.removed, exp_r.active,
                             got.status, got.track_id, got.removed, got.active);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] track_id;
    logic [4:0]  removed_count;
    logic [4:0]  active_count;

    track_table_scoreboard sb;
    bit          no_idle;
    logic [31:0] clock_ms;
    logic [11:0] spot_x[$];
    logic [11:0] spot_y[$];

    nearest_neighbor_track_table_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .x_pos(x_pos), .y_pos(y_pos), .now_ms(now_ms),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .track_id(track_id),
        .removed_count(removed_count), .active_count(active_count)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            out_ready = no_idle || ($urandom_range(0, 99) >= 15);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result({status, track_id, removed_count, active_count});

    task automatic send_item(logic f, logic [11:0] x, logic [11:0] y, logic [31:0] t);
        while (!no_idle && $urandom_range(0, 99) < 15)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        func = f;
        x_pos = x;
        y_pos = y;
        now_ms = t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_transaction(f, x, y, t);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (24) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        drain();
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic detect(logic [11:0] x, logic [11:0] y);
        spot_x.insert(spot_x.size(), x);
        spot_y.insert(spot_y.size(), y);
        if (spot_x.size() > 24)
        begin
            void'(spot_x.pop_front());
            void'(spot_y.pop_front());
        end
        send_item(1'b0, x, y, clock_ms);
    endtask

    task automatic close_frame();
        send_item(1'b1, 12'($urandom), 12'($urandom), clock_ms);
    endtask

    task automatic random_frame();
        int          n;
        int          j;
        int          span;
        logic [11:0] x;
        logic [11:0] y;
        if ($urandom_range(0, 19) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 3000);
        n = $urandom_range(0, 8);
        span = (sb.gate > 2) ? (sb.gate * 4 / 5) : 1;
        if (span > 600)
            span = 600;
        for (int i = 0; i < n; i++)
        begin
            if (spot_x.size() > 0 && $urandom_range(0, 9) < 7)
            begin
                j = $urandom_range(0, spot_x.size() - 1);
                x = spot_x[j] + 12'($urandom_range(0, 2 * span) - span);
                y = spot_y[j] + 12'($urandom_range(0, 2 * span) - span);
            end
            else
            begin
                x = $urandom;
                y = $urandom;
            end
            detect(x, y);
        end
        close_frame();
    endtask

    logic [11:0] gate_set[6];
    logic [19:0] tmo_set[6];

    initial
    begin
        sb = new();
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = nntt_pkg::CFG_GATE;
        cfg_data = '0;
        in_valid = 0;
        func = 0;
        x_pos = '0;
        y_pos = '0;
        now_ms = '0;
        no_idle = 0;
        clock_ms = 0;
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        close_frame();
        clock_ms = 10;
        detect(12'd100, 12'd100);
        detect(12'd105, 12'd100);
        clock_ms = 20;
        close_frame();
        detect(12'd102, 12'd100);
        detect(12'd1000, 12'd1000);
        detect(12'd200, 12'd200);
        detect(12'd210, 12'd200);
        close_frame();
        detect(12'd205, 12'd200);
        detect(12'd1040, 12'd1000);
        detect(12'd4095, 12'd4095);
        detect(12'd0, 12'd0);
        clock_ms = 32'hFFFF_FFF0;
        close_frame();
        detect(12'd4090, 12'd4095);
        clock_ms = 32'd5;
        close_frame();
        clock_ms = 32'd5000;
        close_frame();

        write_reg(nntt_pkg::CFG_GATE, {20'hFFFFF, 12'd0});
        write_reg(nntt_pkg::CFG_TMO, {12'hABC, 20'hFFFFF});
        detect(12'd300, 12'd300);
        close_frame();
        detect(12'd300, 12'd300);
        write_reg(nntt_pkg::CFG_GATE, 32'd4095);
        close_frame();
        detect(12'd0, 12'd4095);
        for (int i = 0; i < 18; i++)
            detect(12'(i * 200), 12'(i * 200));
        close_frame();
        write_reg(nntt_pkg::CFG_TMO, 32'd0);
        clock_ms = clock_ms + 1;
        close_frame();

        gate_set = '{12'd1, 12'd4095, 12'd40, 12'd0, 12'd200, 12'd12};
        tmo_set  = '{20'd0, 20'hFFFFF, 20'd2000, 20'd5000, 20'd800, 20'd3000};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(nntt_pkg::CFG_GATE, {20'($urandom_range(0, 1048575)), gate_set[p]});
            write_reg(nntt_pkg::CFG_TMO, {12'($urandom), tmo_set[p]});
            no_idle = (p == 2);
            repeat (24) random_frame();
        end

        no_idle = 1;
        write_reg(nntt_pkg::CFG_GATE, 32'd1);
        write_reg(nntt_pkg::CFG_TMO, 32'd0);
        for (int fr = 0; fr < 8; fr++)
        begin
            clock_ms = clock_ms + 1;
            for (int i = 0; i < 12; i++)
                send_item(1'b0, 12'($urandom), 12'($urandom), clock_ms);
            close_frame();
        end
        no_idle = 0;
        write_reg(nntt_pkg::CFG_GATE, 32'd40);
        write_reg(nntt_pkg::CFG_TMO, 32'd2000);
        repeat (10) random_frame();

        drain();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
